// ===== rtl/sab_pkg.sv =====
// ----------------------------------------------------------------------------
// sab_pkg
// Shared types, codes and helpers for the slot availability bitmap.
// ----------------------------------------------------------------------------
package sab_pkg;

  localparam int MODE_W   = 3;
  localparam int IDX_W    = 6;
  localparam int CNT_W    = 7;
  localparam int STATUS_W = 2;
  localparam int BYTE_W   = 8;

  localparam logic [BYTE_W-1:0] TOP_BIT = 8'b1000_0000;

  localparam logic [MODE_W-1:0] MODE_FIND        = 3'd0;
  localparam logic [MODE_W-1:0] MODE_SET_AVAIL   = 3'd1;
  localparam logic [MODE_W-1:0] MODE_SET_UNAVAIL = 3'd2;
  localparam logic [MODE_W-1:0] MODE_ADD         = 3'd3;
  localparam logic [MODE_W-1:0] MODE_LIST        = 3'd4;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_RANGE = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RMW,
    S_SCAN,
    S_LIST,
    S_EMIT
  } state_t;

  typedef struct packed {
    logic                valid;
    logic [IDX_W-1:0]    found_index;
    logic                found;
    logic [STATUS_W-1:0] status;
    logic [CNT_W-1:0]    slot_count;
    logic                last;
  } beat_t;

  // position of the first set bit counted from the MSB
  function automatic logic [2:0] first_one(input logic [BYTE_W-1:0] m);
    logic [2:0] k;
    logic       hit;
    k   = 3'd0;
    hit = 1'b0;
    for (int i = 0; i < BYTE_W; i++) begin
      if (!hit && m[BYTE_W-1-i]) begin
        k   = 3'(i);
        hit = 1'b1;
      end
    end
    return k;
  endfunction

endpackage

// ===== rtl/sab_if.sv =====
// ----------------------------------------------------------------------------
// sab_if
// Request and result channels of the slot availability bitmap.
// ----------------------------------------------------------------------------
interface sab_in_if;
  import sab_pkg::*;
  logic              valid;
  logic              ready;
  logic [MODE_W-1:0] mode;
  logic [IDX_W-1:0]  slot_index;

  modport source (output valid, mode, slot_index, input ready);
  modport sink   (input valid, mode, slot_index, output ready);
endinterface

interface sab_out_if;
  import sab_pkg::*;
  logic                valid;
  logic                ready;
  logic [IDX_W-1:0]    found_index;
  logic                found;
  logic [STATUS_W-1:0] status;
  logic [CNT_W-1:0]    slot_count;
  logic                last;

  modport source (output valid, found_index, found, status, slot_count, last, input ready);
  modport sink   (input valid, found_index, found, status, slot_count, last, output ready);
endinterface

// ===== rtl/sab_ram.sv =====
// ----------------------------------------------------------------------------
// sab_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module sab_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/sab_ctrl.sv =====
// ----------------------------------------------------------------------------
// sab_ctrl
// Request sequencer: byte-wise bitmap scan, read-modify-write and slot count.
// ----------------------------------------------------------------------------
module sab_ctrl #(
  parameter int MAX_SLOTS = 64,
  parameter int NBYTES    = (MAX_SLOTS + 7) / 8,
  parameter int BAW       = (NBYTES > 1) ? $clog2(NBYTES) : 1
) (
  input  logic            clk,
  input  logic            rst_n,
  sab_in_if.sink          in_ch,
  output sab_pkg::beat_t  emit_o,
  input  logic            emit_ok_i,
  output logic            ram_we,
  output logic [BAW-1:0]  ram_waddr,
  output logic [7:0]      ram_wdata,
  output logic            ram_re,
  output logic [BAW-1:0]  ram_raddr,
  input  logic [7:0]      ram_rdata
);
  import sab_pkg::*;

  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_SLOTS);

  state_t              state_r, state_nxt;
  logic [MODE_W-1:0]   mode_r, mode_nxt;
  logic [IDX_W-1:0]    idx_r, idx_nxt;
  logic [BAW-1:0]      byte_r, byte_nxt;
  logic [BYTE_W-1:0]   mask_r, mask_nxt;
  logic [IDX_W-1:0]    res_idx_r, res_idx_nxt;
  logic                res_found_r, res_found_nxt;
  logic [STATUS_W-1:0] res_status_r, res_status_nxt;
  logic [NBYTES-1:0]   vld_r, vld_nxt;
  logic [CNT_W-1:0]    total_r, total_nxt;

  logic [BYTE_W-1:0]   rbyte, inr, hits, unav, mod_byte, cur_clr;
  logic [CNT_W-1:0]    slot_base;
  logic                last_byte;
  logic [2:0]          fk, lk;
  logic [BAW-1:0]      byte_inc;

  assign rbyte     = vld_r[byte_r] ? ram_rdata : '0;
  assign slot_base = CNT_W'({byte_r, 3'b000});
  assign last_byte = (byte_r == BAW'((total_r - CNT_W'(1)) >> 3));
  assign byte_inc  = byte_r + BAW'(1);
  assign hits      = rbyte & inr;
  assign unav      = ~rbyte & inr;
  assign fk        = first_one(hits);
  assign lk        = first_one(mask_r);
  assign cur_clr   = mask_r & ~(TOP_BIT >> lk);

  always_comb begin
    for (int k = 0; k < BYTE_W; k++) begin
      inr[BYTE_W-1-k] = (slot_base + CNT_W'(k)) < total_r;
    end
  end

  always_comb begin
    unique case (mode_r)
      MODE_SET_AVAIL:   mod_byte = rbyte | (TOP_BIT >> idx_r[2:0]);
      MODE_SET_UNAVAIL: mod_byte = rbyte & ~(TOP_BIT >> idx_r[2:0]);
      default:          mod_byte = rbyte & ~(TOP_BIT >> total_r[2:0]);
    endcase
  end

  always_comb begin
    state_nxt      = state_r;
    mode_nxt       = mode_r;
    idx_nxt        = idx_r;
    byte_nxt       = byte_r;
    mask_nxt       = mask_r;
    res_idx_nxt    = res_idx_r;
    res_found_nxt  = res_found_r;
    res_status_nxt = res_status_r;
    vld_nxt        = vld_r;
    total_nxt      = total_r;
    in_ch.ready    = 1'b0;
    emit_o         = '0;
    ram_we         = 1'b0;
    ram_waddr      = byte_r;
    ram_wdata      = mod_byte;
    ram_re         = 1'b0;
    ram_raddr      = byte_r;

    unique case (state_r)
      S_IDLE: begin
        in_ch.ready = 1'b1;
        if (in_ch.valid) begin
          mode_nxt       = in_ch.mode;
          idx_nxt        = in_ch.slot_index;
          res_idx_nxt    = '0;
          res_found_nxt  = 1'b0;
          res_status_nxt = ST_OK;
          state_nxt      = S_EMIT;
          case (in_ch.mode) inside
            MODE_FIND, MODE_LIST: begin
              if (total_r != '0) begin
                ram_re    = 1'b1;
                ram_raddr = '0;
                byte_nxt  = '0;
                state_nxt = S_SCAN;
              end
            end
            MODE_SET_AVAIL, MODE_SET_UNAVAIL: begin
              if (CNT_W'(in_ch.slot_index) >= total_r) begin
                res_status_nxt = ST_RANGE;
              end else begin
                ram_re    = 1'b1;
                ram_raddr = BAW'(in_ch.slot_index >> 3);
                byte_nxt  = BAW'(in_ch.slot_index >> 3);
                state_nxt = S_RMW;
              end
            end
            MODE_ADD: begin
              if (total_r >= MAX_CNT) begin
                res_status_nxt = ST_FULL;
              end else begin
                ram_re    = 1'b1;
                ram_raddr = BAW'(total_r >> 3);
                byte_nxt  = BAW'(total_r >> 3);
                state_nxt = S_RMW;
              end
            end
            default: ;
          endcase
        end
      end

      S_RMW: begin
        ram_we          = 1'b1;
        vld_nxt[byte_r] = 1'b1;
        if (mode_r == MODE_ADD) begin
          total_nxt = total_r + CNT_W'(1);
        end
        state_nxt = S_EMIT;
      end

      S_SCAN: begin
        if (mode_r == MODE_FIND) begin
          if (hits != '0) begin
            res_idx_nxt   = IDX_W'(slot_base + CNT_W'(fk));
            res_found_nxt = 1'b1;
            state_nxt     = S_EMIT;
          end else if (last_byte) begin
            state_nxt = S_EMIT;
          end else begin
            ram_re    = 1'b1;
            ram_raddr = byte_inc;
            byte_nxt  = byte_inc;
          end
        end else begin
          mask_nxt = unav;
          if (unav != '0) begin
            state_nxt = S_LIST;
          end else if (last_byte) begin
            state_nxt = S_EMIT;
          end else begin
            ram_re    = 1'b1;
            ram_raddr = byte_inc;
            byte_nxt  = byte_inc;
          end
        end
      end

      S_LIST: begin
        // one slot held back so the final beat can carry last
        if (!res_found_r || emit_ok_i) begin
          if (res_found_r) begin
            emit_o.valid       = 1'b1;
            emit_o.found_index = res_idx_r;
            emit_o.found       = 1'b1;
            emit_o.status      = ST_OK;
            emit_o.slot_count  = total_r;
            emit_o.last        = 1'b0;
          end
          res_idx_nxt   = IDX_W'(slot_base + CNT_W'(lk));
          res_found_nxt = 1'b1;
          mask_nxt      = cur_clr;
          if (cur_clr == '0) begin
            if (last_byte) begin
              state_nxt = S_EMIT;
            end else begin
              ram_re    = 1'b1;
              ram_raddr = byte_inc;
              byte_nxt  = byte_inc;
              state_nxt = S_SCAN;
            end
          end
        end
      end

      S_EMIT: begin
        if (emit_ok_i) begin
          emit_o.valid       = 1'b1;
          emit_o.found_index = res_idx_r;
          emit_o.found       = res_found_r;
          emit_o.status      = res_status_r;
          emit_o.slot_count  = total_r;
          emit_o.last        = 1'b1;
          state_nxt          = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      vld_r   <= '0;
      total_r <= '0;
    end else begin
      state_r <= state_nxt;
      vld_r   <= vld_nxt;
      total_r <= total_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mode_r       <= mode_nxt;
    idx_r        <= idx_nxt;
    byte_r       <= byte_nxt;
    mask_r       <= mask_nxt;
    res_idx_r    <= res_idx_nxt;
    res_found_r  <= res_found_nxt;
    res_status_r <= res_status_nxt;
  end

endmodule

// ===== rtl/sab_out_stage.sv =====
// ----------------------------------------------------------------------------
// sab_out_stage
// Result register between the sequencer and the result channel.
// ----------------------------------------------------------------------------
module sab_out_stage (
  input  logic           clk,
  input  logic           rst_n,
  input  sab_pkg::beat_t emit_i,
  output logic           emit_ok_o,
  sab_out_if.source      out_ch
);
  import sab_pkg::*;

  logic                vld_r, vld_nxt;
  logic [IDX_W-1:0]    idx_r;
  logic                found_r;
  logic [STATUS_W-1:0] status_r;
  logic [CNT_W-1:0]    count_r;
  logic                last_r;

  assign emit_ok_o = !vld_r || out_ch.ready;

  always_comb begin
    vld_nxt = vld_r;
    if (emit_i.valid) begin
      vld_nxt = 1'b1;
    end else if (out_ch.ready) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_i.valid) begin
      idx_r    <= emit_i.found_index;
      found_r  <= emit_i.found;
      status_r <= emit_i.status;
      count_r  <= emit_i.slot_count;
      last_r   <= emit_i.last;
    end
  end

  assign out_ch.valid       = vld_r;
  assign out_ch.found_index = idx_r;
  assign out_ch.found       = found_r;
  assign out_ch.status      = status_r;
  assign out_ch.slot_count  = count_r;
  assign out_ch.last        = last_r;

endmodule

// ===== rtl/slot_availability_bitmap_top.sv =====
// ----------------------------------------------------------------------------
// slot_availability_bitmap_top
// Slot availability bitmap: find, set, add and list over a byte-wide RAM.
//
//   channel  dir  payload
//   in_ch    in   mode, slot_index
//   out_ch   out  found_index, found, status, slot_count, last
//
// Set and add: RAM read, write back, result beat.
// Refused set or add, unused mode: accept, result beat.
// Find: one bitmap byte per cycle from the RAM port.
// List: as find, plus one result beat per unavailable slot.
// Reset clears the bitmap at once through per-byte valid flags.
// A stalled result beat holds the list scan; a new request is taken when idle.
// ----------------------------------------------------------------------------
module slot_availability_bitmap_top #(
  parameter int MAX_SLOTS = 64
) (
  input logic       clk,
  input logic       rst_n,
  sab_in_if.sink    in_ch,
  sab_out_if.source out_ch
);
  import sab_pkg::*;

  localparam int NBYTES = (MAX_SLOTS + 7) / 8;
  localparam int BAW    = (NBYTES > 1) ? $clog2(NBYTES) : 1;

  beat_t             emit;
  logic              emit_ok;
  logic              ram_we;
  logic [BAW-1:0]    ram_waddr;
  logic [BYTE_W-1:0] ram_wdata;
  logic              ram_re;
  logic [BAW-1:0]    ram_raddr;
  logic [BYTE_W-1:0] ram_rdata;

  sab_ctrl #(
    .MAX_SLOTS (MAX_SLOTS),
    .NBYTES    (NBYTES),
    .BAW       (BAW)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .emit_o    (emit),
    .emit_ok_i (emit_ok),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_re    (ram_re),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata)
  );

  sab_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (NBYTES),
    .AW    (BAW)
  ) u_bitmap (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  sab_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .emit_i    (emit),
    .emit_ok_o (emit_ok),
    .out_ch    (out_ch)
  );

endmodule

// ===== rtl/sab_checker.sv =====
// ----------------------------------------------------------------------------
// sab_checker
// Port-level checks of the slot availability bitmap, bound to the top level.
// ----------------------------------------------------------------------------
module sab_checker #(
  parameter int MAX_SLOTS = 64
) (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [5:0] out_found_index,
  input logic       out_found,
  input logic [1:0] out_status,
  input logic [6:0] out_slot_count,
  input logic       out_last
);
  import sab_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result beat dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_found_index) && $stable(out_found) &&
      $stable(out_status) && $stable(out_slot_count) && $stable(out_last))
    else $error("result beat changed while stalled");

  a_one_req: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request taken while previous one in progress");

  a_mid_list: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> out_found && out_status == ST_OK)
    else $error("non-final beat is not a listed slot");

  a_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_slot_count <= CNT_W'(MAX_SLOTS))
    else $error("slot count above maximum");

endmodule

bind slot_availability_bitmap_top sab_checker #(
  .MAX_SLOTS (MAX_SLOTS)
) u_sab_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_ch.valid),
  .in_ready        (in_ch.ready),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .out_found_index (out_ch.found_index),
  .out_found       (out_ch.found),
  .out_status      (out_ch.status),
  .out_slot_count  (out_ch.slot_count),
  .out_last        (out_ch.last)
);
